/* src/gss_pkg.sv */
// Shared types, constants and the interior-point helper for the golden-section search unit.
// No dependencies; every other file imports this package.
package gss_pkg;

    localparam int PT_W          = 32;   // Q16.16 points and values
    localparam int STOP_W        = 33;   // bracket widths need one extra bit
    localparam int STEP_W        = 7;
    localparam int TOL_W         = 16;
    localparam int MAX_STEPS_DEF = 64;

    localparam int S_TDATA_W = 3 * PT_W;                    // 96, already whole bytes
    localparam int M_TDATA_W = ((2 * PT_W + 1 + 7) / 8) * 8; // 65 bits padded to 72

    // Golden ratios in Q0.16; they sum to exactly 1.0
    localparam logic [TOL_W-1:0] G2_Q16    = 16'd40504;
    localparam logic [TOL_W-1:0] G1_Q16    = 16'd25032;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    localparam logic OP_START = 1'b0;
    localparam logic OP_VALUE = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_F1    = 5'b00010,
        PH_F2    = 5'b00100,
        PH_STEP  = 5'b01000,
        PH_FINAL = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PROBE   = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_IGNORED = 2'd2
    } t_kind;

    typedef logic signed [PT_W-1:0] t_pt;

    typedef struct packed {
        logic op;
        t_pt  lower_bound;
        t_pt  upper_bound;
        t_pt  function_value;
    } t_item;

    typedef struct packed {
        t_phase                    phase;
        t_pt                       a0;
        t_pt                       a1;
        t_pt                       a2;
        t_pt                       a3;
        t_pt                       f1;
        t_pt                       f2;
        logic signed [STOP_W-1:0]  stop_width;
        logic                      side;
        logic [STEP_W-1:0]         steps;
    } t_state;

    typedef struct packed {
        t_kind kind;
        t_pt   point;
        t_pt   min_value;
        logic  hit_step_cap;
    } t_result;

    // y + round(w * d / 2^16), with d = x - y; the result always lies between x and y
    function automatic t_pt mix_pt(input t_pt y, input logic signed [STOP_W-1:0] d,
                                   input logic [TOL_W-1:0] w);
        logic signed [STOP_W+TOL_W:0] prod;
        logic signed [STOP_W+TOL_W:0] rnd;
        prod = $signed({1'b0, w}) * d;
        rnd  = prod + (STOP_W+TOL_W+1)'(32768);
        return y + t_pt'(rnd[TOL_W+PT_W-1:TOL_W]);
    endfunction

endpackage

/* src/gss_step.sv */
// Next-state and result logic of the golden-section search: one item against the stored state.
// Depends on gss_pkg.
module gss_step
    import gss_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  t_item             i_item,
    input  t_state            i_st,
    input  logic [TOL_W-1:0]  i_tol,
    output t_state            o_st,
    output t_result           o_res
);

    logic signed [STOP_W-1:0]        d_in;
    logic signed [STOP_W-1:0]        dn_in;
    logic signed [STOP_W+TOL_W:0]    stop_prod;
    t_pt                             a1_start;
    t_pt                             a2_start;
    logic signed [STOP_W-1:0]        d_cur;
    logic                            too_wide;
    logic                            go_step;
    logic [STOP_W-1:0]               mid_sum;
    t_pt                             mid;
    t_pt                             a2_right;
    t_pt                             a1_left;
    logic                            set_f1;
    logic                            set_f2;
    t_pt                             fe1;
    t_pt                             fe2;

    // start: bracket split and stop width
    assign d_in      = {i_item.upper_bound[PT_W-1], i_item.upper_bound}
                     - {i_item.lower_bound[PT_W-1], i_item.lower_bound};
    assign dn_in     = {i_item.lower_bound[PT_W-1], i_item.lower_bound}
                     - {i_item.upper_bound[PT_W-1], i_item.upper_bound};
    assign stop_prod = $signed({1'b0, i_tol}) * d_in;
    assign a1_start  = mix_pt(i_item.upper_bound, dn_in, G2_Q16);
    assign a2_start  = mix_pt(i_item.upper_bound, dn_in, G1_Q16);

    // width test and midpoint on the current bracket
    assign d_cur    = {i_st.a3[PT_W-1], i_st.a3} - {i_st.a0[PT_W-1], i_st.a0};
    assign too_wide = d_cur > i_st.stop_width;
    assign go_step  = too_wide && (i_st.steps < STEP_W'(MAX_STEPS));
    assign mid_sum  = {i_st.a1[PT_W-1], i_st.a1} + {i_st.a2[PT_W-1], i_st.a2};
    assign mid      = t_pt'(mid_sum[STOP_W-1:1]);

    // new probe for either direction; the bracket shifts before the mix
    assign a2_right = mix_pt(i_st.a2,
                             {i_st.a3[PT_W-1], i_st.a3} - {i_st.a2[PT_W-1], i_st.a2}, G1_Q16);
    assign a1_left  = mix_pt(i_st.a0,
                             {i_st.a1[PT_W-1], i_st.a1} - {i_st.a0[PT_W-1], i_st.a0}, G2_Q16);

    // incoming value lands before the compare
    assign set_f1 = (i_st.phase == PH_STEP) && !i_st.side;
    assign set_f2 = (i_st.phase == PH_F2) || ((i_st.phase == PH_STEP) && i_st.side);
    assign fe1    = set_f1 ? i_item.function_value : i_st.f1;
    assign fe2    = set_f2 ? i_item.function_value : i_st.f2;

    always_comb begin
        o_st       = i_st;
        o_res      = '0;
        o_res.kind = KIND_PROBE;
        if (i_item.op == OP_START) begin
            // a start drops any running search
            o_st.a0         = i_item.lower_bound;
            o_st.a3         = i_item.upper_bound;
            o_st.a1         = a1_start;
            o_st.a2         = a2_start;
            o_st.f1         = '0;
            o_st.f2         = '0;
            o_st.stop_width = stop_prod[STOP_W+TOL_W-1:TOL_W];
            o_st.side       = 1'b0;
            o_st.steps      = '0;
            o_st.phase      = PH_F1;
            o_res.point     = a1_start;
        end else begin
            unique case (i_st.phase) inside
                PH_F1: begin
                    o_st.f1     = i_item.function_value;
                    o_st.phase  = PH_F2;
                    o_res.point = i_st.a2;
                end
                PH_F2, PH_STEP: begin
                    o_st.f1 = fe1;
                    o_st.f2 = fe2;
                    if (go_step) begin
                        if (fe1 > fe2) begin
                            o_st.a0     = i_st.a1;
                            o_st.a1     = i_st.a2;
                            o_st.f1     = fe2;
                            o_st.a2     = a2_right;
                            o_st.side   = 1'b1;
                            o_res.point = a2_right;
                        end else begin
                            // ties keep the left side
                            o_st.a3     = i_st.a2;
                            o_st.a2     = i_st.a1;
                            o_st.f2     = fe1;
                            o_st.a1     = a1_left;
                            o_st.side   = 1'b0;
                            o_res.point = a1_left;
                        end
                        o_st.steps = i_st.steps + STEP_W'(1);
                        o_st.phase = PH_STEP;
                    end else begin
                        o_st.phase  = PH_FINAL;
                        o_res.point = mid;
                    end
                end
                PH_FINAL: begin
                    o_st.phase         = PH_IDLE;
                    o_res.kind         = KIND_DONE;
                    o_res.point        = mid;
                    o_res.min_value    = i_item.function_value;
                    o_res.hit_step_cap = too_wide;
                end
                default: begin
                    o_st.phase = PH_IDLE;
                    o_res.kind = KIND_IGNORED;
                end
            endcase
        end
    end

endmodule

/* src/gss_core.sv */
// Search state registers around the next-state logic.
// Depends on gss_pkg and gss_step.
module gss_core
    import gss_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_item             i_item,
    input  logic [TOL_W-1:0]  i_tol,
    output t_result           o_res
);

    t_state r_st;
    t_state n_st;

    gss_step #(
        .MAX_STEPS (MAX_STEPS)
    ) u_step (
        .i_item (i_item),
        .i_st   (r_st),
        .i_tol  (i_tol),
        .o_st   (n_st),
        .o_res  (o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // idle phase in the top field, everything else zero
            r_st <= t_state'({PH_IDLE, {($bits(t_state)-$bits(t_phase)){1'b0}}});
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    a_steps_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.steps <= STEP_W'(MAX_STEPS))
        else $error("step count past cap");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.op == OP_START) |=> (r_st.phase == PH_F1) && (r_st.steps == '0))
        else $error("start did not restart the search");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_res.kind == KIND_DONE) |=> r_st.phase == PH_IDLE)
        else $error("search done but not idle");

    a_step_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_STEP |-> r_st.steps != '0)
        else $error("step phase without a counted step");

endmodule

/* src/gss_out_reg.sv */
// Result register and master-side stream handshake.
// Depends on gss_pkg.
module gss_out_reg
    import gss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_result               i_res,
    output logic                  o_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // point, min_value, hit_step_cap, zero pad
    output logic [1:0]            m_axis_tuser   // kind
);

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {{(M_TDATA_W-2*PT_W-1){1'b0}}, r_res.hit_step_cap,
                            r_res.min_value, r_res.point};
    assign m_axis_tuser  = r_res.kind;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

/* src/golden_section_search_unit.sv */
// Golden-section search unit: top level with tolerance register, request register and core.
// Depends on gss_pkg, gss_core and gss_out_reg.
//
// A request is held in the request register, then its result in the result register.
// Throughput: one request per cycle while results are taken; the input register refills in the
// cycle its request moves on, and the result register frees in the cycle its result is taken.
// Reset (i_rst_n low, synchronous): search goes idle, both registers empty, tolerance = 7.
//
// Each request is registered, then one pass of logic (one compare, constant-ratio multiplies,
// or on a start the tolerance multiply) updates the bracket and writes the result register.
// The search state updates when the request leaves the input register, so the next request,
// already waiting, sees it in the following cycle. The outside evaluator sets the real pace:
// each probe result is answered by a value request.
module golden_section_search_unit
    import gss_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF   // step cap, 4 to 127
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tolerance_fraction write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TOL_W-1:0]      i_cfg_data,
    // requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // lower_bound, upper_bound, function_value
    input  logic [0:0]            s_axis_tuser,  // op
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // point, min_value, hit_step_cap, zero pad
    output logic [1:0]            m_axis_tuser   // kind
);

    logic [TOL_W-1:0] r_tol;
    logic             r_in_vld;
    t_item            r_item;
    t_item            n_item;
    logic             in_take;
    logic             out_free;
    logic             fire;
    t_result          res;

    // tolerance register; only read when a start request passes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // request register: refills in the same cycle it drains
    assign fire          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign n_item.op             = s_axis_tuser[0];
    assign n_item.lower_bound    = t_pt'(s_axis_tdata[PT_W-1:0]);
    assign n_item.upper_bound    = t_pt'(s_axis_tdata[2*PT_W-1:PT_W]);
    assign n_item.function_value = t_pt'(s_axis_tdata[3*PT_W-1:2*PT_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= n_item;
        end
    end

    gss_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_tol   (r_tol),
        .o_res   (res)
    );

    gss_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_res         (res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* tb/sv/tb_golden_section_search_unit.sv */
// Self-checking bench for golden_section_search_unit: a directed table, then random searches
// scored against an in-bench golden-section predictor over several tolerance settings.
// Depends on gss_pkg and the golden_section_search_unit RTL.
module tb_golden_section_search_unit;
    import gss_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int NUM_STEP_CAP = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 140;
    localparam int NUM_ROWS     = 19;
    localparam int NUM_PHASES   = 5;

    typedef logic signed [63:0] t_wide;

    typedef struct {
        logic    op;
        t_pt     lo;
        t_pt     hi;
        t_pt     fv;
        bit      pinned;   // use res below instead of the predictor
        t_result res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [TOL_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // lower_bound, upper_bound, function_value
    logic [0:0]           s_axis_tuser;   // op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // point, min_value, hit_step_cap, zero pad
    logic [1:0]           m_axis_tuser;   // kind

    // predictor state
    t_phase            mdl_phase;
    t_wide             mdl_pts [4];
    t_wide             mdl_vals [2];
    t_wide             mdl_stop;
    bit                mdl_side;
    logic [STEP_W-1:0] mdl_steps;
    logic [TOL_W-1:0]  mdl_tol;

    t_result gss_responses_due [$];
    t_pt     last_point;
    int      errors = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;
    bit      hold_ask = 1'b0;
    bit      hold_taken = 1'b0;

    golden_section_search_unit #(
        .MAX_STEPS (NUM_STEP_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[golden_section_search_unit] ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    // w on x, 1-w on y, rounded to nearest; >>> on a signed value floors
    function automatic t_wide golden_mix(t_wide x, t_wide y, t_wide w);
        return (w * x + (t_wide'(65536) - w) * y + t_wide'(32768)) >>> 16;
    endfunction

    function automatic t_wide bracket_mid();
        return (mdl_pts[1] + mdl_pts[2]) >>> 1;
    endfunction

    function automatic bit bracket_wide();
        return (mdl_pts[3] - mdl_pts[0]) > mdl_stop;
    endfunction

    function automatic t_result make_res(t_kind k, t_wide p, t_wide v, bit cap);
        t_result r;
        r.kind         = k;
        r.point        = p[31:0];
        r.min_value    = v[31:0];
        r.hit_step_cap = cap;
        return r;
    endfunction

    // both interior values known: shrink toward the lower one, or go to the midpoint probe
    function automatic t_result narrow_bracket();
        t_result r;
        if (bracket_wide() && mdl_steps < NUM_STEP_CAP) begin
            if (mdl_vals[0] > mdl_vals[1]) begin
                mdl_pts[0]  = mdl_pts[1];
                mdl_pts[1]  = mdl_pts[2];
                mdl_vals[0] = mdl_vals[1];
                mdl_pts[2]  = golden_mix(mdl_pts[3], mdl_pts[1], G1_Q16);
                mdl_side    = 1'b1;
                r = make_res(KIND_PROBE, mdl_pts[2], 0, 1'b0);
            end else begin
                // ties keep the left side
                mdl_pts[3]  = mdl_pts[2];
                mdl_pts[2]  = mdl_pts[1];
                mdl_vals[1] = mdl_vals[0];
                mdl_pts[1]  = golden_mix(mdl_pts[2], mdl_pts[0], G2_Q16);
                mdl_side    = 1'b0;
                r = make_res(KIND_PROBE, mdl_pts[1], 0, 1'b0);
            end
            mdl_steps = mdl_steps + 1'b1;
            mdl_phase = PH_STEP;
        end else begin
            mdl_phase = PH_FINAL;
            r = make_res(KIND_PROBE, bracket_mid(), 0, 1'b0);
        end
        return r;
    endfunction

    function automatic t_result predict_gss_response(logic op, t_pt lo, t_pt hi, t_pt fv);
        t_result r;
        t_wide   v;
        v = fv;
        if (op == OP_START) begin
            mdl_pts[0]  = lo;
            mdl_pts[3]  = hi;
            mdl_pts[1]  = golden_mix(mdl_pts[0], mdl_pts[3], G2_Q16);
            mdl_pts[2]  = golden_mix(mdl_pts[0], mdl_pts[3], G1_Q16);
            mdl_vals[0] = 0;
            mdl_vals[1] = 0;
            mdl_stop    = (t_wide'(mdl_tol) * (mdl_pts[3] - mdl_pts[0])) >>> 16;
            mdl_side    = 1'b0;
            mdl_steps   = '0;
            mdl_phase   = PH_F1;
            r = make_res(KIND_PROBE, mdl_pts[1], 0, 1'b0);
        end else begin
            case (mdl_phase)
                PH_F1: begin
                    mdl_vals[0] = v;
                    mdl_phase   = PH_F2;
                    r = make_res(KIND_PROBE, mdl_pts[2], 0, 1'b0);
                end
                PH_F2: begin
                    mdl_vals[1] = v;
                    r = narrow_bracket();
                end
                PH_STEP: begin
                    mdl_vals[mdl_side] = v;
                    r = narrow_bracket();
                end
                PH_FINAL: begin
                    mdl_phase = PH_IDLE;
                    r = make_res(KIND_DONE, bracket_mid(), v, bracket_wide());
                end
                default: begin
                    mdl_phase = PH_IDLE;
                    r = make_res(KIND_IGNORED, 0, 0, 1'b0);
                end
            endcase
        end
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic t_row make_row(logic op, t_pt lo, t_pt hi, t_pt fv, bit pinned,
                                      t_kind k, t_pt p, t_pt mv, bit cap);
        t_row row;
        row.op     = op;
        row.lo     = lo;
        row.hi     = hi;
        row.fv     = fv;
        row.pinned = pinned;
        row.res    = make_res(k, p, mv, cap);
        return row;
    endfunction

    // objective seen by the evaluator: noise, a valley at c, flat, or a peak at c
    function automatic t_pt objective(int fmode, t_pt p, t_pt c);
        t_wide d;
        d = (t_wide'(p) - t_wide'(c)) >>> 1;
        if (d < 0)
            d = -d;
        case (fmode)
            0:       return $urandom;
            1:       return t_pt'(d);
            2:       return c;
            default: return -t_pt'(d);
        endcase
    endfunction

    // present one request, hold it until accepted, log its expected response
    task automatic send_request(logic op, t_pt lo, t_pt hi, t_pt fv, bit pinned,
                                t_result pin_res);
        t_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {fv, hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_gss_response(op, lo, hi, fv);
        gss_responses_due.push_back(pinned ? pin_res : r);
        last_point = r.point;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // stop offering, then wait for every expected response
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (gss_responses_due.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with nothing in flight
    task automatic write_tolerance(logic [TOL_W-1:0] tol);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tol;
        do @(posedge i_clk); while (!o_cfg_ready);
        mdl_tol = tol;
        i_cfg_valid <= 1'b0;
    endtask

    // whole searches with random brackets and objectives, some restarts and stray values
    task automatic run_searches(int n_items);
        int  sent;
        int  mode;
        int  fmode;
        t_pt lo;
        t_pt hi;
        t_pt c;
        t_pt tmp;
        sent = 0;
        while (sent < n_items) begin
            mode  = $urandom_range(0, 9);
            fmode = $urandom_range(0, 3);
            if (mode < 5) begin
                lo = $urandom;
                hi = $urandom;
                if (mode < 4 && lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end else begin
                lo = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
                tmp = $urandom_range(0, 32'h0010_0000);
                if (mode < 8)
                    hi = lo + tmp;
                else if (mode == 8)
                    hi = lo - tmp;    // reversed bracket
                else
                    hi = lo;          // empty bracket
            end
            c = t_pt'((t_wide'(lo) + t_wide'(hi)) >>> 1) + t_pt'($urandom_range(0, 32'hFFFF));
            send_request(OP_START, lo, hi, $urandom, 1'b0, '0);
            sent++;
            while (mdl_phase != PH_IDLE) begin
                if (sent < n_items && $urandom_range(0, 49) == 0)
                    break;            // abandon: the next start drops this search
                send_request(OP_VALUE, $urandom, $urandom, objective(fmode, last_point, c),
                             1'b0, '0);
                sent++;
            end
            if (mdl_phase == PH_IDLE && $urandom_range(0, 4) == 0) begin
                send_request(OP_VALUE, $urandom, $urandom, $urandom, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off so the unit backs up
    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_ask && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ---------------- checking ----------------

    task automatic note_mismatch(string what, t_result got, t_result want);
        errors++;
        $display("%0t mismatch (%s): got %0d %h %h %b, want %0d %h %h %b",
                 $time, what, got.kind, got.point, got.min_value, got.hit_step_cap,
                 want.kind, want.point, want.min_value, want.hit_step_cap);
    endtask

    always @(posedge i_clk) begin : response_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind         = t_kind'(m_axis_tuser);
            got.point        = m_axis_tdata[31:0];
            got.min_value    = m_axis_tdata[63:32];
            got.hit_step_cap = m_axis_tdata[64];
            if (gss_responses_due.size() == 0) begin
                note_mismatch("unexpected response", got, got);
            end else begin
                want = gss_responses_due.pop_front();
                if (got.kind != want.kind)
                    note_mismatch("kind", got, want);
                if (got.point != want.point)
                    note_mismatch("point", got, want);
                if (got.min_value != want.min_value)
                    note_mismatch("min_value", got, want);
                if (got.hit_step_cap != want.hit_step_cap)
                    note_mismatch("hit_step_cap", got, want);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        t_row             rows [NUM_ROWS];
        logic [TOL_W-1:0] tol_plan [NUM_PHASES];
        int               k;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;

        mdl_phase   = PH_IDLE;
        mdl_pts     = '{0, 0, 0, 0};
        mdl_vals    = '{0, 0};
        mdl_stop    = 0;
        mdl_side    = 1'b0;
        mdl_steps   = '0;
        mdl_tol     = TOL_RESET;
        last_point  = '0;

        // value while idle, then a zero-width search read off by hand
        rows[0]  = make_row(OP_VALUE, 0, 0, 32'h7FFF_FFFF, 1, KIND_IGNORED, 0, 0, 0);
        rows[1]  = make_row(OP_START, 0, 0, 0, 1, KIND_PROBE, 0, 0, 0);
        rows[2]  = make_row(OP_VALUE, 0, 0, 32'h8000_0000, 1, KIND_PROBE, 0, 0, 0);
        rows[3]  = make_row(OP_VALUE, 0, 0, 32'h7FFF_FFFF, 1, KIND_PROBE, 0, 0, 0);
        rows[4]  = make_row(OP_VALUE, 0, 0, 32'h8000_0000, 1, KIND_DONE, 0, 32'h8000_0000, 0);
        rows[5]  = make_row(OP_VALUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                            KIND_IGNORED, 0, 0, 0);
        // widest bracket, move right, then a tie
        rows[6]  = make_row(OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, KIND_PROBE, 0, 0, 0);
        rows[7]  = make_row(OP_VALUE, 0, 0, 32'h0005_0000, 0, KIND_PROBE, 0, 0, 0);
        rows[8]  = make_row(OP_VALUE, 0, 0, 32'h0003_0000, 0, KIND_PROBE, 0, 0, 0);
        rows[9]  = make_row(OP_VALUE, 0, 0, 32'h0003_0000, 0, KIND_PROBE, 0, 0, 0);
        rows[10] = make_row(OP_VALUE, 0, 0, 0, 0, KIND_PROBE, 0, 0, 0);
        // restart while busy with a reversed bracket: straight to the midpoint
        rows[11] = make_row(OP_START, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, KIND_PROBE, 0, 0, 0);
        rows[12] = make_row(OP_VALUE, 0, 0, 32'hFFFF_FFFF, 0, KIND_PROBE, 0, 0, 0);
        rows[13] = make_row(OP_VALUE, 0, 0, 32'h0000_0001, 0, KIND_PROBE, 0, 0, 0);
        rows[14] = make_row(OP_VALUE, 0, 0, 32'h1234_5678, 0, KIND_PROBE, 0, 0, 0);
        // empty bracket away from zero
        rows[15] = make_row(OP_START, 32'h0012_0000, 32'h0012_0000, 0, 0, KIND_PROBE, 0, 0, 0);
        rows[16] = make_row(OP_VALUE, 0, 0, 32'h0000_0010, 0, KIND_PROBE, 0, 0, 0);
        rows[17] = make_row(OP_VALUE, 0, 0, 32'hFFFF_0000, 0, KIND_PROBE, 0, 0, 0);
        rows[18] = make_row(OP_VALUE, 0, 0, 32'h7FFF_0000, 0, KIND_PROBE, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NUM_ROWS; k++)
            send_request(rows[k].op, rows[k].lo, rows[k].hi, rows[k].fv, rows[k].pinned,
                         rows[k].res);

        // zero tolerance runs into the step cap; last phase back at the reset value, no idling
        tol_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), TOL_RESET};
        for (k = 0; k < NUM_PHASES; k++) begin
            wait_drained();
            write_tolerance(tol_plan[k]);
            quiet = (k == NUM_PHASES - 1);
            if (k == 1)
                hold_ask = 1'b1;
            run_searches(PHASE_ITEMS);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[golden_section_search_unit] OK");
        else
            $display("[golden_section_search_unit] ERROR");
        $finish;
    end

endmodule
